/* rtl/core/bfm_pkg.sv */
// Shared types, constants and divide helpers for the 3x3 box filter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package bfm_pkg;

    // Default frame limits handed to the top-level parameters
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Fixed field widths
    localparam int CFG_W = 9;
    localparam int PIX_W = 8;
    localparam int POS_W = 8;
    localparam int SUM_W = 12;   // nine 8-bit cells
    localparam int COL_SUM_W = 10;   // three 8-bit cells

    // Word opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // Configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Window column being read or summed
    typedef enum logic [1:0] {
        COL_LEFT,
        COL_MID,
        COL_RIGHT
    } t_col;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic acc_clr;
        logic rd_en;
        t_col rd_col;
        logic acc_en;
        t_col acc_col;
        logic div_en;
        logic commit;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic act;
        logic emit;
        logic out_free;
    } t_sts;

    // floor(x / 3) for x below 2048: reciprocal multiply
    function automatic logic [9:0] div_by3(input logic [10:0] i_x);
        logic [21:0] prod;
        prod = 22'(i_x) * 22'd1366;
        return prod[21:12];
    endfunction

    // floor(x / 9) for any 12-bit x: reciprocal multiply
    function automatic logic [8:0] div_by9(input logic [11:0] i_x);
        logic [24:0] prod;
        prod = 25'(i_x) * 25'd7282;
        return prod[24:16];
    endfunction

endpackage

/* rtl/core/bfm_in_if.sv */
// Input channel of the 3x3 box filter: valid/ready plus one input word.
// Depends on bfm_pkg for field widths.
interface bfm_in_if;
    import bfm_pkg::*;

    logic             valid;
    logic             ready;
    logic             opcode;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

/* rtl/core/bfm_out_if.sv */
// Output channel of the 3x3 box filter: valid/ready plus one result word.
// Depends on bfm_pkg for field widths.
interface bfm_out_if;
    import bfm_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input frame_last, output ready);
endinterface

/* rtl/core/bfm_ctrl.sv */
// Sequencer of the 3x3 box filter: takes a word, steps the column reads,
// the divide and the commit. Depends on bfm_pkg for command/status types.
module bfm_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  bfm_pkg::t_sts  i_sts,
    output bfm_pkg::t_cmd  o_cmd
);
    import bfm_pkg::*;

    localparam logic [1:0] LAST_STEP = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_DIV,
        S_COMMIT
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_step, n_step;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // drop words that do nothing in the current phase
                priority if (!i_sts.act) begin
                    n_state = S_IDLE;
                end else if (i_sts.emit) begin
                    o_cmd.acc_clr = 1'b1;
                    n_step        = '0;
                    n_state       = S_READ;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_READ: begin
                // read one column ahead, sum the column read last cycle
                if (r_step != LAST_STEP) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_col = t_col'(r_step);
                end
                if (r_step != '0) begin
                    o_cmd.acc_en  = 1'b1;
                    o_cmd.acc_col = t_col'(r_step - 2'd1);
                end
                n_step = r_step + 2'd1;
                if (r_step == LAST_STEP) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                n_state      = S_COMMIT;
            end
            S_COMMIT: begin
                // hold a result while the output register still holds an untaken word
                if (!i_sts.emit || i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule

/* rtl/core/bfm_dp.sv */
// Datapath of the 3x3 box filter: frame registers, position counters,
// three rotating line stores, window sum, divide and output register. Uses bfm_pkg.
module bfm_dp #(
    parameter int MAX_WIDTH  = bfm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bfm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [bfm_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_opcode,
    input  logic [bfm_pkg::PIX_W-1:0]   i_pixel,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bfm_pkg::PIX_W-1:0]   o_pixel,
    output logic [bfm_pkg::POS_W-1:0]   o_row,
    output logic [bfm_pkg::POS_W-1:0]   o_col,
    output logic                        o_last,
    input  bfm_pkg::t_cmd               i_cmd,
    output bfm_pkg::t_sts               o_sts
);
    import bfm_pkg::*;

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int NBANK = 3;

    // Frame size as last column / last row index
    logic [CW-1:0] r_wl;
    logic [RW-1:0] r_hl;

    // Input and output raster positions, phase flag, bank pointer
    logic [CW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_row, r_out_row;
    logic          r_draining;
    logic [1:0]    r_cur_sel;

    // Captured word, window sum, mean
    logic             r_op;
    logic [PIX_W-1:0] r_pix;
    logic [SUM_W-1:0] r_acc;
    logic [PIX_W-1:0] r_mean;

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_o_pix;
    logic [POS_W-1:0] r_o_row, r_o_col;
    logic             r_o_last;

    logic [1:0]       mid_b, abv_b, wr_bank;
    logic             wr_en, rotate, in_last, out_last, emit_px;
    logic [CW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data [NBANK];
    logic             shift, top_v, bot_v, left_v, right_v, col_v;
    logic [PIX_W-1:0] top_d, mid_d, bot_d;
    logic [COL_SUM_W-1:0] col_sum;
    logic [1:0]       n_rows, n_cols;
    logic [3:0]       cell_cnt;
    logic [9:0]       q3, q6;
    logic [8:0]       q9;
    logic [PIX_W-1:0] mean;

    // Effective last column of a written width
    function automatic logic [CW-1:0] last_col(input logic [CFG_W-1:0] i_v);
        if (i_v == '0) begin
            return '0;
        end else if (int'(i_v) > MAX_WIDTH) begin
            return CW'(MAX_WIDTH - 1);
        end else begin
            return CW'(i_v - 1'b1);
        end
    endfunction

    // Effective last row of a written height
    function automatic logic [RW-1:0] last_row(input logic [CFG_W-1:0] i_v);
        if (i_v == '0) begin
            return '0;
        end else if (int'(i_v) > MAX_HEIGHT) begin
            return RW'(MAX_HEIGHT - 1);
        end else begin
            return RW'(i_v - 1'b1);
        end
    endfunction

    // Bank roles: current, middle (one row up), above (two rows up)
    assign mid_b = (r_cur_sel == 2'd0) ? 2'd2 : r_cur_sel - 2'd1;
    assign abv_b = (r_cur_sel == 2'd2) ? 2'd0 : r_cur_sel + 2'd1;

    // Raster bookkeeping
    assign in_last  = (r_in_row == r_hl) && (r_in_col == r_wl);
    assign out_last = (r_out_row == r_hl) && (r_out_col == r_wl);
    assign rotate   = (r_in_col == '0) && (r_in_row != '0);
    assign emit_px  = !r_draining &&
                      ((r_in_row > RW'(1)) || ((r_in_row == RW'(1)) && (r_in_col != '0)));
    assign wr_en    = i_cmd.commit && (r_op == OP_PIXEL);
    assign wr_bank  = rotate ? abv_b : r_cur_sel;

    // Status to the controller
    assign o_sts.act      = (r_op == OP_PIXEL) ? !r_draining : r_draining;
    assign o_sts.emit     = (r_op == OP_PIXEL) ? emit_px : r_draining;
    assign o_sts.out_free = !r_out_valid || i_ready;

    // Read address of the window column, clamped at frame edges
    always_comb begin
        unique case (i_cmd.rd_col)
            COL_LEFT:  rd_addr = (r_out_col == '0) ? r_out_col : r_out_col - CW'(1);
            COL_RIGHT: rd_addr = (r_out_col == r_wl) ? r_out_col : r_out_col + CW'(1);
            default:   rd_addr = r_out_col;
        endcase
    end

    // Line stores, one read port and one write port each
    for (genvar b = 0; b < NBANK; b++) begin : g_bank
        logic [PIX_W-1:0] r_line [MAX_WIDTH];
        logic [PIX_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (wr_en && (wr_bank == 2'(b))) begin
                r_line[r_in_col] <= r_pix;
            end
            if (i_cmd.rd_en) begin
                r_rd <= r_line[rd_addr];
            end
        end

        assign rd_data[b] = r_rd;
    end

    // Window geometry: on the bottom row while draining, rows slide up one bank
    assign shift   = r_draining && (r_out_row == r_hl);
    assign top_v   = (r_out_row != '0);
    assign bot_v   = !shift;
    assign left_v  = (r_out_col != '0);
    assign right_v = (r_out_col != r_wl);

    always_comb begin
        unique case (i_cmd.acc_col)
            COL_LEFT:  col_v = left_v;
            COL_RIGHT: col_v = right_v;
            default:   col_v = 1'b1;
        endcase
    end

    // Column sum; the incoming pixel stands in for the unstored bottom-right cell
    assign top_d = shift ? rd_data[mid_b] : rd_data[abv_b];
    assign mid_d = shift ? rd_data[r_cur_sel] : rd_data[mid_b];
    assign bot_d = ((r_op == OP_PIXEL) && (i_cmd.acc_col == COL_RIGHT)) ?
                   r_pix : rd_data[r_cur_sel];
    assign col_sum = (top_v ? COL_SUM_W'(top_d) : '0) + COL_SUM_W'(mid_d) +
                     (bot_v ? COL_SUM_W'(bot_d) : '0);

    // Cell count of the window and the floored mean
    assign n_rows   = 2'd1 + 2'(top_v) + 2'(bot_v);
    assign n_cols   = 2'd1 + 2'(left_v) + 2'(right_v);
    assign cell_cnt = 4'(n_rows) * 4'(n_cols);
    assign q3       = div_by3(r_acc[10:0]);
    assign q6       = div_by3(r_acc[11:1]);
    assign q9       = div_by9(r_acc);

    always_comb begin
        unique case (cell_cnt)
            4'd2:    mean = r_acc[8:1];
            4'd3:    mean = q3[PIX_W-1:0];
            4'd4:    mean = r_acc[9:2];
            4'd6:    mean = q6[PIX_W-1:0];
            4'd9:    mean = q9[PIX_W-1:0];
            default: mean = r_acc[PIX_W-1:0];
        endcase
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_pix <= i_pixel;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_en && col_v) begin
            r_acc <= r_acc + SUM_W'(col_sum);
        end
        if (i_cmd.div_en) begin
            r_mean <= mean;
        end
        if (i_cmd.commit && o_sts.emit) begin
            r_o_pix  <= r_mean;
            r_o_row  <= POS_W'(r_out_row);
            r_o_col  <= POS_W'(r_out_col);
            r_o_last <= (r_op == OP_DRAIN) && out_last;
        end
    end

    // Control registers: frame size, positions, phase, bank pointer, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl        <= '0;
            r_hl        <= '0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_draining  <= 1'b0;
            r_cur_sel   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // a register write also restarts the frame
                if (i_cfg_idx == REG_FRAME_WIDTH) begin
                    r_wl <= last_col(i_cfg_data);
                end else begin
                    r_hl <= last_row(i_cfg_data);
                end
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_draining <= 1'b0;
            end else if (i_cmd.commit) begin
                if (r_op == OP_PIXEL) begin
                    if (rotate) begin
                        r_cur_sel <= abv_b;
                    end
                    if (r_in_col == r_wl) begin
                        r_in_col <= '0;
                        r_in_row <= r_in_row + RW'(1);
                    end else begin
                        r_in_col <= r_in_col + CW'(1);
                    end
                    if (in_last) begin
                        r_draining <= 1'b1;
                    end
                    if (emit_px) begin
                        if (r_out_col == r_wl) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + RW'(1);
                        end else begin
                            r_out_col <= r_out_col + CW'(1);
                        end
                    end
                end else if (out_last) begin
                    // last word of the frame: start over
                    r_in_col   <= '0;
                    r_in_row   <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_draining <= 1'b0;
                end else if (r_out_col == r_wl) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                end else begin
                    r_out_col <= r_out_col + CW'(1);
                end
            end

            if (i_cmd.commit && o_sts.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_o_pix;
    assign o_row   = r_o_row;
    assign o_col   = r_o_col;
    assign o_last  = r_o_last;

endmodule

/* rtl/core/box_filter_3x3_edge_mean.sv */
// Top level of the 3x3 box filter with edge-aware mean: controller and datapath.
// Depends on bfm_pkg, bfm_in_if, bfm_out_if, bfm_ctrl and bfm_dp.
//
//   channel  dir  handshake        word
//   i_pix    in   valid/ready      opcode, pixel_in
//   o_res    out  valid/ready      pixel_out, out_row, out_col, frame_last
//   i_cfg_*  in   write enable     i_cfg_idx selects width (0) or height (1)
//
// A word with a result steps through accept, decide, reads of the three window
// columns one per cycle from the line stores, divide and commit. A pixel word
// without a result goes accept, decide, commit; an ignored word accept, decide.
// Reset is synchronous and needs no clearing pass; unwritten store cells are read
// only where the window masks them out. A new word is accepted while a result
// waits in the output register; commit of the next result holds until it is taken.
module box_filter_3x3_edge_mean #(
    parameter int MAX_WIDTH  = bfm_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bfm_pkg::DEF_MAX_HEIGHT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_idx,
    input  logic [bfm_pkg::CFG_W-1:0] i_cfg_data,
    bfm_in_if.sink                    i_pix,
    bfm_out_if.source                 o_res
);
    import bfm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    bfm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_pix.valid),
        .o_ready (i_pix.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Line stores, counters and arithmetic
    bfm_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_opcode   (i_pix.opcode),
        .i_pixel    (i_pix.pixel_in),
        .o_valid    (o_res.valid),
        .i_ready    (o_res.ready),
        .o_pixel    (o_res.pixel_out),
        .o_row      (o_res.out_row),
        .o_col      (o_res.out_col),
        .o_last     (o_res.frame_last),
        .i_cmd      (cmd),
        .o_sts      (sts)
    );

endmodule

/* bench/box_filter_3x3_edge_mean_tb.sv */
// Self-checking bench for the 3x3 edge-aware box filter: random raster frames and drain words.
// A scoreboard class tracks the line stores and predicts every result word.
// Depends on bfm_pkg, bfm_in_if, bfm_out_if and box_filter_3x3_edge_mean.
`timescale 1ns / 100ps

localparam int LINE_DEPTH = bfm_pkg::DEF_MAX_WIDTH;
localparam int ROW_LIMIT  = bfm_pkg::DEF_MAX_HEIGHT;

typedef struct packed {
    logic [bfm_pkg::PIX_W-1:0] pixel;
    logic [bfm_pkg::POS_W-1:0] row;
    logic [bfm_pkg::POS_W-1:0] col;
    logic                      last;
} t_mean_word;

class mean_tracker;
    bit [bfm_pkg::CFG_W-1:0] width_reg;
    bit [bfm_pkg::CFG_W-1:0] height_reg;
    bit [bfm_pkg::PIX_W-1:0] row_above [LINE_DEPTH];
    bit [bfm_pkg::PIX_W-1:0] row_mid   [LINE_DEPTH];
    bit [bfm_pkg::PIX_W-1:0] row_cur   [LINE_DEPTH];
    int unsigned             pix_count;
    int unsigned             out_count;
    bit                      draining;
    t_mean_word              pending_means [$];
    int                      errors;

    function new();
        width_reg  = 1;
        height_reg = 1;
        foreach (row_cur[i]) begin
            row_above[i] = '0;
            row_mid[i]   = '0;
            row_cur[i]   = '0;
        end
        errors = 0;
        restart();
    endfunction

    function void restart();
        pix_count = 0;
        out_count = 0;
        draining  = 1'b0;
        pending_means.delete();
    endfunction

    // Zero acts as one, oversize clamps to the store limit
    function int unsigned clamp_dim(bit [bfm_pkg::CFG_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function int unsigned frame_width();
        return clamp_dim(width_reg, LINE_DEPTH);
    endfunction

    function int unsigned frame_height();
        return clamp_dim(height_reg, ROW_LIMIT);
    endfunction

    function void set_reg(logic idx, bit [bfm_pkg::CFG_W-1:0] v);
        if (idx == bfm_pkg::REG_FRAME_WIDTH) width_reg = v;
        else height_reg = v;
        restart();
    endfunction

    // Stored cell of row q, column c, with lrow the newest stored row
    function int unsigned stored_cell(int unsigned lrow, int unsigned q, int unsigned c);
        if (q > lrow) return 0;
        case (lrow - q)
            0: return row_cur[c];
            1: return row_mid[c];
            2: return row_above[c];
            default: return 0;
        endcase
    endfunction

    // Floor of the mean over the in-frame part of the window around position p
    function bit [bfm_pkg::PIX_W-1:0] window_mean(int unsigned p, bit has_new, int nrow,
                                                  int ncol, bit [bfm_pkg::PIX_W-1:0] npix);
        int unsigned w, h, r, c, lrow, sum, cnt;
        int rr, cc;
        w    = frame_width();
        h    = frame_height();
        r    = p / w;
        c    = p % w;
        lrow = (pix_count - 1) / w;
        sum  = 0;
        cnt  = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = int'(r) + dr;
                cc = int'(c) + dc;
                if (rr < 0 || rr >= int'(h) || cc < 0 || cc >= int'(w)) continue;
                if (has_new && rr == nrow && cc == ncol) sum += npix;
                else sum += stored_cell(lrow, rr, cc);
                cnt++;
            end
        end
        return 8'(sum / cnt);
    endfunction

    // Advance the filter state by one accepted input word
    function void take_word(logic op, logic [bfm_pkg::PIX_W-1:0] pix);
        int unsigned w, total, k, p;
        int nrow, ncol;
        t_mean_word res;
        w     = frame_width();
        total = w * frame_height();
        p     = out_count;
        if (op == bfm_pkg::OP_PIXEL) begin
            if (draining) return;
            k    = pix_count;
            nrow = k / w;
            ncol = k % w;
            if (k >= w + 1) begin
                res.pixel = window_mean(p, 1'b1, nrow, ncol, pix);
                res.row   = 8'(p / w);
                res.col   = 8'(p % w);
                res.last  = 1'b0;
                pending_means.push_back(res);
                out_count++;
            end
            // rotate the row stores on a new row
            if (ncol == 0 && k != 0) begin
                row_above = row_mid;
                row_mid   = row_cur;
            end
            row_cur[ncol] = pix;
            pix_count++;
            if (pix_count >= total) draining = 1'b1;
        end else begin
            if (!draining) return;
            res.pixel = window_mean(p, 1'b0, 0, 0, '0);
            res.row   = 8'(p / w);
            res.col   = 8'(p % w);
            res.last  = 1'b0;
            out_count++;
            if (out_count >= total) begin
                res.last  = 1'b1;
                pix_count = 0;
                out_count = 0;
                draining  = 1'b0;
            end
            pending_means.push_back(res);
        end
    endfunction

    // Compare one accepted result word with the oldest prediction
    function void check_word(t_mean_word got);
        t_mean_word exp_w;
        if (pending_means.size() == 0) begin
            $error("result word with no prediction: row %0d col %0d pixel_out %0d",
                   got.row, got.col, got.pixel);
            errors++;
            return;
        end
        exp_w = pending_means.pop_front();
        if (got.pixel !== exp_w.pixel) begin
            $error("pixel_out mismatch: expected %0d, got %0d", exp_w.pixel, got.pixel);
            errors++;
        end
        if (got.row !== exp_w.row) begin
            $error("out_row mismatch: expected %0d, got %0d", exp_w.row, got.row);
            errors++;
        end
        if (got.col !== exp_w.col) begin
            $error("out_col mismatch: expected %0d, got %0d", exp_w.col, got.col);
            errors++;
        end
        if (got.last !== exp_w.last) begin
            $error("frame_last mismatch: expected %0d, got %0d", exp_w.last, got.last);
            errors++;
        end
    endfunction
endclass

module box_filter_3x3_edge_mean_tb;
    import bfm_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_TARGET   = 1700;
    localparam int TIMEOUT_NS    = 20_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic             cfg_idx;
    logic [CFG_W-1:0] cfg_data;

    bfm_in_if  pix_if ();
    bfm_out_if res_if ();

    mean_tracker sb;
    bit          quiet;
    int          counted;

    box_filter_3x3_edge_mean uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(9, 30);
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return PIX_W'($urandom);
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(int small_max, int big_max);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r < 3) return CFG_W'($urandom_range(small_max + 1, big_max));
        return CFG_W'($urandom_range(1, small_max));
    endfunction

    // Present one input word and hold it until accepted
    task automatic send_word(input logic op, input logic [PIX_W-1:0] pix);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.opcode   <= op;
        pix_if.pixel_in <= pix;
        do @(posedge i_clk); while (!pix_if.ready);
        counted++;
        sb.take_word(op, pix);
    endtask

    // Drop valid and wait for every predicted word to come out
    task automatic wait_results();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_means.size() != 0) @(posedge i_clk);
    endtask

    // Write one register once the block has gone quiet
    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    // Stream a frame; cut >= 0 stops after that many pixels and leaves it open
    task automatic run_frame(input int cut, input int noise_pct, input bit pause_mid);
        int unsigned n;
        n = (cut >= 0) ? cut : sb.frame_width() * sb.frame_height();
        for (int unsigned i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) wait_results();
            if ($urandom_range(0, 99) < noise_pct) send_word(OP_DRAIN, PIX_W'($urandom));
            send_word(OP_PIXEL, pick_pixel());
        end
        if (cut >= 0) return;
        while (sb.draining) begin
            if ($urandom_range(0, 99) < noise_pct) send_word(OP_PIXEL, pick_pixel());
            send_word(OP_DRAIN, PIX_W'($urandom));
        end
    endtask

    // Output side: take result words with random stalls
    initial begin
        int stall_left;
        int run_left;
        t_mean_word got;
        stall_left = 0;
        run_left   = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got.pixel = res_if.pixel_out;
                got.row   = res_if.out_row;
                got.col   = res_if.out_col;
                got.last  = res_if.frame_last;
                sb.check_word(got);
            end
            if (quiet) begin
                res_if.ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                res_if.ready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                run_left   = $urandom_range(0, 12);
                res_if.ready <= 1'b1;
            end
        end
    end

    // Main sequence
    initial begin
        bit need_cfg;
        sb = new();
        quiet   = 1'b0;
        counted = 0;
        i_rst_n         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_FRAME_WIDTH;
        cfg_data        <= '0;
        pix_if.valid    <= 1'b0;
        pix_if.opcode   <= OP_PIXEL;
        pix_if.pixel_in <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 1x1 frame from reset: stray pixel while draining, stray drain after
        send_word(OP_PIXEL, 8'hFF);
        send_word(OP_PIXEL, 8'h00);
        send_word(OP_DRAIN, 8'hA5);
        send_word(OP_DRAIN, 8'h00);

        // zero dimensions act as one
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        send_word(OP_PIXEL, 8'h80);
        send_word(OP_DRAIN, 8'hFF);

        // 3x2 checkerboard of extremes, early drain dropped, pause for results
        write_reg(REG_FRAME_WIDTH, 9'd3);
        write_reg(REG_FRAME_HEIGHT, 9'd2);
        send_word(OP_DRAIN, 8'hFF);
        for (int i = 0; i < 6; i++) begin
            if (i == 5) wait_results();
            send_word(OP_PIXEL, (i % 2 == 1) ? 8'h00 : 8'hFF);
        end
        send_word(OP_DRAIN, 8'h00);
        send_word(OP_PIXEL, 8'h55);
        while (sb.draining) send_word(OP_DRAIN, 8'hFF);

        // restart in the middle of a frame by a register write
        write_reg(REG_FRAME_WIDTH, 9'd2);
        write_reg(REG_FRAME_HEIGHT, 9'd3);
        run_frame(4, 0, 1'b0);

        // widest and tallest frames, oversized values clamp
        write_reg(REG_FRAME_WIDTH, 9'h1FF);
        write_reg(REG_FRAME_HEIGHT, 9'd2);
        run_frame(-1, 5, 1'b0);
        write_reg(REG_FRAME_WIDTH, 9'd1);
        write_reg(REG_FRAME_HEIGHT, 9'd300);
        run_frame(-1, 5, 1'b1);

        // random frames, mostly small; a few cut short and restarted
        need_cfg = 1'b1;
        while (counted < ITEM_TARGET) begin
            if (need_cfg || $urandom_range(0, 3) == 0) begin
                write_reg(REG_FRAME_WIDTH, pick_dim(12, 40));
                write_reg(REG_FRAME_HEIGHT, pick_dim(8, 20));
                need_cfg = 1'b0;
            end
            quiet = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 7) == 0) begin
                run_frame(int'($urandom_range(0, sb.frame_width() * sb.frame_height() - 1)),
                          8, 1'b0);
                need_cfg = 1'b1;
            end else begin
                run_frame(-1, 8, $urandom_range(0, 15) == 0);
            end
        end
        quiet = 1'b0;

        // drain the pipe and let any late word show up
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS box_filter_3x3_edge_mean");
        end else begin
            $display("FAIL box_filter_3x3_edge_mean");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("FAIL box_filter_3x3_edge_mean");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/bfm_pkg.sv
rtl/core/bfm_in_if.sv
rtl/core/bfm_out_if.sv
rtl/core/bfm_ctrl.sv
rtl/core/bfm_dp.sv
rtl/core/box_filter_3x3_edge_mean.sv
bench/box_filter_3x3_edge_mean_tb.sv
